FILE: rtl/riff_wav_pcm_header_parser_core_macros.svh
// Assertion macros shared by the WAV header parser RTL.
`ifndef RIFF_WAV_PCM_HEADER_PARSER_CORE_MACROS_SVH
`define RIFF_WAV_PCM_HEADER_PARSER_CORE_MACROS_SVH
`ifndef SYNTH
`define RWP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rwp assertion failed");
`define RWP_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rwp forbidden condition seen");
`else
`define RWP_ASSERT(lbl, clk, rst_n, prop)
`define RWP_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/rwp_pkg.sv
// Package with types and constants of the WAV header parser.
`default_nettype none
package rwp_pkg;
    localparam int unsigned FMT_WINDOW = 16;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW = $clog2(Q_DEPTH);

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HDR  = 3'd1;
    localparam logic [2:0] ST_NO_FMT   = 3'd2;
    localparam logic [2:0] ST_NO_DATA  = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_NOT_PCM  = 3'd5;
    localparam logic [2:0] ST_BAD_LAY  = 3'd6;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CHUNK  = 3'd1,
        PH_FMT    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_DATA   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    // One classified byte: an optional sample and an optional status.
    typedef struct packed {
        logic        has_sample;
        logic [7:0]  sample;
        logic        has_status;
        logic [2:0]  status;
        logic [1:0]  fmt;
        logic [31:0] rate;
        logic [31:0] len;
    } t_event;
endpackage
`default_nettype wire

FILE: rtl/rwp_front.sv
// Front end: parses file bytes and classifies each into a result event.
`default_nettype none
`include "riff_wav_pcm_header_parser_core_macros.svh"
module rwp_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eof,
    output rwp_pkg::t_event      o_event
);
    rwp_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_len, n_len;
    logic [31:0] r_tag, n_tag;
    logic [15:0] r_enc, n_enc;
    logic [15:0] r_chn, n_chn;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_sent, n_sent;

    logic [31:0] len_base, len_full;
    logic [32:0] pad_cur, pad_new, cnt_inc;
    logic [2:0]  fin_st;
    logic [1:0]  fin_fc;
    rwp_pkg::t_event ev;

    // Outcome of a complete data chunk, from the stored format fields.
    always_comb begin
        fin_st = rwp_pkg::ST_BAD_LAY;
        fin_fc = 2'd0;
        if (r_enc != 16'd1) begin
            fin_st = rwp_pkg::ST_NOT_PCM;
        end else if ((r_chn == 16'd1 || r_chn == 16'd2) &&
                     (r_bits == 16'd8 || r_bits == 16'd16)) begin
            fin_st = rwp_pkg::ST_OK;
            fin_fc = {r_chn == 16'd2, r_bits == 16'd16};
        end
    end

    assign len_base = (r_cnt == 32'd0) ? 32'd0 : r_len;
    assign len_full = len_base | {i_byte, 24'd0};
    assign pad_cur  = {1'b0, r_len} + {32'd0, r_len[0]};
    assign pad_new  = {1'b0, len_full} + {32'd0, len_full[0]};
    assign cnt_inc  = {1'b0, r_cnt} + 33'd1;

    // Next state and the event caused by this byte.
    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_len = r_len; n_tag = r_tag;
        n_enc = r_enc; n_chn = r_chn; n_rate = r_rate; n_bits = r_bits;
        n_fmt_seen = r_fmt_seen; n_sent = r_sent;
        ev = '0;
        unique case (r_phase)
            rwp_pkg::PH_HEADER: begin
                n_tag = {r_tag[23:0], i_byte};
                if (r_cnt == 32'd3 && n_tag != rwp_pkg::TAG_RIFF) begin
                    ev.has_status = 1'b1; ev.status = rwp_pkg::ST_BAD_HDR;
                end else if (r_cnt >= 32'd11) begin
                    if (n_tag != rwp_pkg::TAG_WAVE) begin
                        ev.has_status = 1'b1; ev.status = rwp_pkg::ST_BAD_HDR;
                    end else begin
                        n_phase = rwp_pkg::PH_CHUNK;
                        n_cnt = 32'd0;
                    end
                end else begin
                    n_cnt = cnt_inc[31:0];
                end
            end
            rwp_pkg::PH_CHUNK: begin
                n_len = len_base;
                if (r_cnt < 32'd4) begin
                    n_tag = {r_tag[23:0], i_byte};
                    n_cnt = cnt_inc[31:0];
                end else if (r_cnt < 32'd7) begin
                    unique case (r_cnt[1:0])
                        2'd0:    n_len = len_base | {24'd0, i_byte};
                        2'd1:    n_len = len_base | {16'd0, i_byte, 8'd0};
                        default: n_len = len_base | {8'd0, i_byte, 16'd0};
                    endcase
                    n_cnt = cnt_inc[31:0];
                end else begin
                    n_len = len_full;
                    n_cnt = 32'd0;
                    if (r_tag == rwp_pkg::TAG_FMT) begin
                        n_enc = '0; n_chn = '0; n_rate = '0; n_bits = '0;
                        if (pad_new == 33'd0) n_fmt_seen = 1'b1;
                        else n_phase = rwp_pkg::PH_FMT;
                    end else if (r_tag == rwp_pkg::TAG_DATA) begin
                        if (!r_fmt_seen) begin
                            ev.has_status = 1'b1; ev.status = rwp_pkg::ST_NO_FMT;
                            ev.len = len_full;
                        end else if (len_full == 32'd0) begin
                            ev.has_status = 1'b1; ev.status = fin_st;
                            ev.fmt = fin_fc; ev.len = len_full;
                        end else begin
                            n_phase = rwp_pkg::PH_DATA;
                        end
                    end else if (pad_new != 33'd0) begin
                        n_phase = rwp_pkg::PH_SKIP;
                    end
                end
            end
            rwp_pkg::PH_FMT, rwp_pkg::PH_SKIP: begin
                if (r_phase == rwp_pkg::PH_FMT && r_cnt < 32'(rwp_pkg::FMT_WINDOW)) begin
                    unique case (r_cnt[3:0])
                        4'd0:    n_enc[7:0]    = i_byte;
                        4'd1:    n_enc[15:8]   = i_byte;
                        4'd2:    n_chn[7:0]    = i_byte;
                        4'd3:    n_chn[15:8]   = i_byte;
                        4'd4:    n_rate[7:0]   = i_byte;
                        4'd5:    n_rate[15:8]  = i_byte;
                        4'd6:    n_rate[23:16] = i_byte;
                        4'd7:    n_rate[31:24] = i_byte;
                        4'd14:   n_bits[7:0]   = i_byte;
                        4'd15:   n_bits[15:8]  = i_byte;
                        default: n_rate = n_rate;
                    endcase
                end
                if (cnt_inc == pad_cur) begin
                    if (r_phase == rwp_pkg::PH_FMT) n_fmt_seen = 1'b1;
                    n_phase = rwp_pkg::PH_CHUNK;
                    n_cnt = 32'd0;
                end else begin
                    n_cnt = cnt_inc[31:0];
                end
            end
            rwp_pkg::PH_DATA: begin
                ev.has_sample = 1'b1;
                ev.sample = i_byte;
                if (cnt_inc == {1'b0, r_len}) begin
                    ev.has_status = 1'b1; ev.status = fin_st;
                    ev.fmt = fin_fc; ev.len = r_len;
                end else begin
                    n_cnt = cnt_inc[31:0];
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        if (ev.has_status) begin
            n_sent = 1'b1;
            n_phase = rwp_pkg::PH_DONE;
        end

        // End of file: report if nothing was reported yet, then restart.
        if (i_eof) begin
            if (!n_sent) begin
                ev.has_status = 1'b1;
                ev.fmt = 2'd0;
                if (n_phase == rwp_pkg::PH_HEADER) begin
                    ev.status = rwp_pkg::ST_BAD_HDR; ev.len = '0;
                end else if (n_phase == rwp_pkg::PH_DATA) begin
                    ev.status = rwp_pkg::ST_TRUNC; ev.len = n_len;
                end else begin
                    ev.status = rwp_pkg::ST_NO_DATA; ev.len = '0;
                end
            end
        end
        ev.rate = ev.has_status ? n_rate : 32'd0;

        if (i_eof) begin
            n_phase = rwp_pkg::PH_HEADER;
            n_cnt = '0; n_len = '0; n_tag = '0;
            n_enc = '0; n_chn = '0; n_rate = '0; n_bits = '0;
            n_fmt_seen = 1'b0; n_sent = 1'b0;
        end
    end

    assign o_event = ev;

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rwp_pkg::PH_HEADER;
            r_cnt <= '0; r_len <= '0; r_tag <= '0;
            r_enc <= '0; r_chn <= '0; r_rate <= '0; r_bits <= '0;
            r_fmt_seen <= 1'b0; r_sent <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_cnt <= n_cnt; r_len <= n_len; r_tag <= n_tag;
            r_enc <= n_enc; r_chn <= n_chn; r_rate <= n_rate; r_bits <= n_bits;
            r_fmt_seen <= n_fmt_seen; r_sent <= n_sent;
        end
    end

    `RWP_ASSERT(a_done_sent, i_clk, i_rst_n, (r_phase == rwp_pkg::PH_DONE) |-> r_sent)
    `RWP_ASSERT(a_eof_restart, i_clk, i_rst_n, (i_take && i_eof) |=> (r_phase == rwp_pkg::PH_HEADER))
endmodule
`default_nettype wire

FILE: rtl/rwp_queue.sv
// Short event queue between the parser front end and the result back end.
`default_nettype none
`include "riff_wav_pcm_header_parser_core_macros.svh"
module rwp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire rwp_pkg::t_event i_data,
    input  wire logic            i_rd,
    output rwp_pkg::t_event      o_data,
    output logic                 o_full,
    output logic                 o_empty
);
    rwp_pkg::t_event r_mem [rwp_pkg::Q_DEPTH];
    logic [rwp_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [rwp_pkg::Q_AW:0]   r_cnt;
    logic do_wr, do_rd;

    assign o_full  = (r_cnt == (rwp_pkg::Q_AW+1)'(rwp_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wp] <= i_data;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_wr) r_wp <= r_wp + 1'b1;
            if (do_rd) r_rp <= r_rp + 1'b1;
            if (do_wr && !do_rd) r_cnt <= r_cnt + 1'b1;
            else if (do_rd && !do_wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    `RWP_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > (rwp_pkg::Q_AW+1)'(rwp_pkg::Q_DEPTH))
endmodule
`default_nettype wire

FILE: rtl/rwp_back.sv
// Back end: unpacks queued events into sample and status results.
`default_nettype none
`include "riff_wav_pcm_header_parser_core_macros.svh"
module rwp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rwp_pkg::t_event i_event,
    input  wire logic            i_q_empty,
    output logic                 o_q_rd,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic                 o_kind,
    output logic [7:0]           o_sample_byte,
    output logic [2:0]           o_status,
    output logic [1:0]           o_format_code,
    output logic [31:0]          o_sample_rate,
    output logic [31:0]          o_data_length,
    output logic                 o_last
);
    rwp_pkg::t_event r_ev;
    logic r_valid;
    logic load;

    // Take the next event when the held one is gone or fully delivered.
    assign load   = !r_valid || (i_pop && !(r_ev.has_sample && r_ev.has_status));
    assign o_q_rd = load && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ev <= i_event;
        end else if (i_pop) begin
            r_ev.has_sample <= 1'b0;
        end
    end

    // Result fields: the sample goes first, then the status.
    assign o_empty       = !r_valid;
    assign o_kind        = !r_ev.has_sample;
    assign o_last        = !r_ev.has_sample;
    assign o_sample_byte = r_ev.has_sample ? r_ev.sample : 8'd0;
    assign o_status      = r_ev.has_sample ? 3'd0 : r_ev.status;
    assign o_format_code = r_ev.has_sample ? 2'd0 : r_ev.fmt;
    assign o_sample_rate = r_ev.has_sample ? 32'd0 : r_ev.rate;
    assign o_data_length = r_ev.has_sample ? 32'd0 : r_ev.len;

    `RWP_ASSERT(a_held_nonempty, i_clk, i_rst_n, r_valid |-> (r_ev.has_sample || r_ev.has_status))
endmodule
`default_nettype wire

FILE: rtl/riff_wav_pcm_header_parser_core.sv
// Top level of the RIFF/WAVE PCM header parser.
// Usage:
//   Input channel: drive i_file_byte and i_end_of_file with push; a byte is
//   taken at a clock edge where push is high and full is low. Mark the last
//   byte of each file with i_end_of_file; the parser then restarts.
//   Result channel: while empty is low the oldest result is on the o_ ports;
//   it is taken at an edge where pop is high. Data-chunk bytes come out as
//   sample results (kind 0), and one status result (kind 1, last 1) closes
//   each file.
//   A result passes through the event queue and the result register before it
//   is visible. Throughput: one byte per cycle while full is low; a byte that
//   yields both its last sample and the status gives the sample, then the status.
//   A four-entry event queue sits between parser and result stage, so full
//   rises only once four events wait in the queue behind the result stage.
//   Reset (synchronous, active low) clears the parser and empties the queue.
`default_nettype none
module riff_wav_pcm_header_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic        i_end_of_file,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_kind,
    output logic [7:0]       o_sample_byte,
    output logic [2:0]       o_status,
    output logic [1:0]       o_format_code,
    output logic [31:0]      o_sample_rate,
    output logic [31:0]      o_data_length,
    output logic             o_last
);
    rwp_pkg::t_event fe_ev, q_ev;
    logic take, q_full, q_empty, q_rd;

    assign full = q_full;
    assign take = push && !q_full;

    rwp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_file_byte),
        .i_eof   (i_end_of_file),
        .o_event (fe_ev)
    );

    rwp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (take && (fe_ev.has_sample || fe_ev.has_status)),
        .i_data  (fe_ev),
        .i_rd    (q_rd),
        .o_data  (q_ev),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rwp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_event       (q_ev),
        .i_q_empty     (q_empty),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (o_kind),
        .o_sample_byte (o_sample_byte),
        .o_status      (o_status),
        .o_format_code (o_format_code),
        .o_sample_rate (o_sample_rate),
        .o_data_length (o_data_length),
        .o_last        (o_last)
    );
endmodule
`default_nettype wire

FILE: verif/tb_riff_wav_pcm_header_parser_core.sv
// Self-checking testbench for the RIFF/WAVE PCM header parser core.
`timescale 1ns / 1ps
`default_nettype none

module tb_riff_wav_pcm_header_parser_core;

    // One expected or observed result.
    typedef struct {
        logic        kind;
        logic [7:0]  sample_byte;
        logic [2:0]  status;
        logic [1:0]  format_code;
        logic [31:0] sample_rate;
        logic [31:0] data_length;
        logic        last;
    } t_wav_result;

    int unsigned mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, wanted %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Scoreboard: parser predictor plus the queue of expected results.
    class wav_scoreboard;
        rwp_pkg::t_phase ph;
        logic [31:0] count, clen, shreg, rate;
        logic [15:0] enc, chans, bits;
        bit          fmt_done, done;
        t_wav_result pending_results[$];

        function new();
            restart();
        endfunction

        function void restart();
            ph = rwp_pkg::PH_HEADER; count = 0; clen = 0; shreg = 0;
            enc = 0; chans = 0; rate = 0; bits = 0; fmt_done = 0; done = 0;
        endfunction

        function void add_status(logic [2:0] st, logic [1:0] fc, logic [31:0] len);
            t_wav_result r;
            r.kind = 1; r.sample_byte = 0; r.status = st;
            r.format_code = (st == rwp_pkg::ST_OK) ? fc : 2'd0;
            r.sample_rate = rate; r.data_length = len; r.last = 1;
            pending_results.insert(pending_results.size(), r);
            done = 1; ph = rwp_pkg::PH_DONE;
        endfunction

        function void close_data();
            if (enc != 16'd1) add_status(rwp_pkg::ST_NOT_PCM, 0, clen);
            else if ((chans == 1 || chans == 2) && (bits == 8 || bits == 16))
                add_status(rwp_pkg::ST_OK, 2'((chans - 1) * 2 + (bits == 16)), clen);
            else add_status(rwp_pkg::ST_BAD_LAY, 0, clen);
        endfunction

        function logic [32:0] padded();
            return {1'b0, clen} + clen[0];
        endfunction

        function void body_byte();
            if ({1'b0, count} + 1 == padded()) begin
                if (ph == rwp_pkg::PH_FMT) fmt_done = 1;
                ph = rwp_pkg::PH_CHUNK; count = 0;
            end else begin
                count++;
            end
        endfunction

        // Notes one accepted file byte and predicts its results.
        function void note_byte(logic [7:0] b, logic eof);
            t_wav_result r;
            case (ph)
                rwp_pkg::PH_HEADER: begin
                    shreg = {shreg[23:0], b};
                    if (count == 3 && shreg != rwp_pkg::TAG_RIFF)
                        add_status(rwp_pkg::ST_BAD_HDR, 0, 0);
                    else if (count >= 11) begin
                        if (shreg != rwp_pkg::TAG_WAVE) add_status(rwp_pkg::ST_BAD_HDR, 0, 0);
                        else begin ph = rwp_pkg::PH_CHUNK; count = 0; end
                    end else count++;
                end
                rwp_pkg::PH_CHUNK: begin
                    if (count == 0) clen = 0;
                    if (count < 4) begin
                        shreg = {shreg[23:0], b}; count++;
                    end else if (count < 7) begin
                        clen |= 32'(b) << (8 * (count - 4)); count++;
                    end else begin
                        clen |= 32'(b) << 24; count = 0;
                        if (shreg == rwp_pkg::TAG_FMT) begin
                            enc = 0; chans = 0; rate = 0; bits = 0;
                            if (padded() == 0) fmt_done = 1;
                            else ph = rwp_pkg::PH_FMT;
                        end else if (shreg == rwp_pkg::TAG_DATA) begin
                            if (!fmt_done) add_status(rwp_pkg::ST_NO_FMT, 0, clen);
                            else if (clen == 0) close_data();
                            else ph = rwp_pkg::PH_DATA;
                        end else if (padded() != 0) ph = rwp_pkg::PH_SKIP;
                    end
                end
                rwp_pkg::PH_FMT: begin
                    case (count)
                        0: enc[7:0] = b;
                        1: enc[15:8] = b;
                        2: chans[7:0] = b;
                        3: chans[15:8] = b;
                        4, 5, 6, 7: rate |= 32'(b) << (8 * (count - 4));
                        14: bits[7:0] = b;
                        15: bits[15:8] = b;
                        default: ;
                    endcase
                    body_byte();
                end
                rwp_pkg::PH_SKIP: body_byte();
                rwp_pkg::PH_DATA: begin
                    r.kind = 0; r.sample_byte = b; r.status = 0; r.format_code = 0;
                    r.sample_rate = 0; r.data_length = 0; r.last = 0;
                    pending_results.insert(pending_results.size(), r);
                    if (count + 1 == clen) close_data();
                    else count++;
                end
                default: ;
            endcase
            if (eof) begin
                if (!done) begin
                    if (ph == rwp_pkg::PH_HEADER) add_status(rwp_pkg::ST_BAD_HDR, 0, 0);
                    else if (ph == rwp_pkg::PH_DATA) add_status(rwp_pkg::ST_TRUNC, 0, clen);
                    else add_status(rwp_pkg::ST_NO_DATA, 0, 0);
                end
                restart();
            end
        endfunction

        // Compares one accepted result with the oldest expectation.
        task check_result(t_wav_result got);
            t_wav_result w;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result kind", got.kind, 0);
                return;
            end
            w = pending_results.pop_front();
            if (got.kind !== w.kind) report_mismatch("kind", got.kind, w.kind);
            if (got.sample_byte !== w.sample_byte)
                report_mismatch("sample_byte", got.sample_byte, w.sample_byte);
            if (got.status !== w.status) report_mismatch("status", got.status, w.status);
            if (got.format_code !== w.format_code)
                report_mismatch("format_code", got.format_code, w.format_code);
            if (got.sample_rate !== w.sample_rate)
                report_mismatch("sample_rate", got.sample_rate, w.sample_rate);
            if (got.data_length !== w.data_length)
                report_mismatch("data_length", got.data_length, w.data_length);
            if (got.last !== w.last) report_mismatch("last", got.last, w.last);
        endtask
    endclass

    logic        i_clk = 0, i_rst_n = 0, push = 0, pop = 0;
    logic [7:0]  i_file_byte = 0;
    logic        i_end_of_file = 0;
    logic        full, empty, o_kind, o_last;
    logic [7:0]  o_sample_byte;
    logic [2:0]  o_status;
    logic [1:0]  o_format_code;
    logic [31:0] o_sample_rate, o_data_length;

    riff_wav_pcm_header_parser_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_file_byte(i_file_byte), .i_end_of_file(i_end_of_file),
        .empty(empty), .pop(pop), .o_kind(o_kind), .o_sample_byte(o_sample_byte),
        .o_status(o_status), .o_format_code(o_format_code),
        .o_sample_rate(o_sample_rate), .o_data_length(o_data_length), .o_last(o_last)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    wav_scoreboard sb = new();
    int unsigned idle_cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned pop_wait = 0;
    bit          random_gaps = 1;
    logic [7:0]  file_bytes[$];

    // Result side: a random wait before each request, check at each accepted one.
    always @(posedge i_clk) begin
        t_wav_result got;
        if (!i_rst_n) begin
            pop <= 0;
        end else begin
            if (pop && !empty) begin
                got.kind = o_kind; got.sample_byte = o_sample_byte; got.status = o_status;
                got.format_code = o_format_code; got.sample_rate = o_sample_rate;
                got.data_length = o_data_length; got.last = o_last;
                sb.check_result(got);
                pop_wait = random_gaps ? $urandom_range(0, 15) : 0;
            end
            if (pop_wait > 0) begin
                pop_wait--;
                pop <= 0;
            end else begin
                pop <= 1;
            end
        end
    end

    // Watchdog on cycles without any accepted request.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sends one byte, after a random gap, and notes it when accepted.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int unsigned gap;
        gap = random_gaps ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) != 0) gap = 0;
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1; i_file_byte <= b; i_end_of_file <= eof;
        do @(posedge i_clk); while (full);
        sb.note_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endtask

    task automatic push_word_le(input logic [31:0] v);
        for (int k = 0; k < 4; k++) add_byte(v[8*k +: 8]);
    endtask

    task automatic push_tag(input logic [31:0] t);
        for (int k = 3; k >= 0; k--) add_byte(t[8*k +: 8]);
    endtask

    task automatic add_header();
        push_tag(rwp_pkg::TAG_RIFF); push_word_le($urandom); push_tag(rwp_pkg::TAG_WAVE);
    endtask

    // Appends a fmt chunk of the given size with the given fields.
    task automatic add_fmt(input int unsigned size, input logic [15:0] enc,
                           input logic [15:0] ch, input logic [31:0] rate,
                           input logic [15:0] bits);
        logic [7:0] body[16];
        push_tag(rwp_pkg::TAG_FMT); push_word_le(size);
        for (int k = 0; k < 16; k++) body[k] = 8'($urandom);
        {body[1], body[0]} = enc; {body[3], body[2]} = ch;
        {body[7], body[6], body[5], body[4]} = rate; {body[15], body[14]} = bits;
        for (int k = 0; k < size + size % 2; k++)
            add_byte(k < 16 ? body[k] : 8'($urandom));
    endtask

    task automatic add_data(input int unsigned size, input int unsigned present);
        push_tag(rwp_pkg::TAG_DATA); push_word_le(size);
        for (int k = 0; k < present; k++) add_byte(8'($urandom));
    endtask

    // Sends the assembled file, marking the last byte (or one more) as end of file.
    task automatic send_file(input int unsigned trailing);
        repeat (trailing) add_byte(8'($urandom));
        if (file_bytes.size() == 0) add_byte(8'($urandom));
        for (int k = 0; k < file_bytes.size(); k++)
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    // A random, mostly well-formed file.
    task automatic random_file();
        int unsigned pick, n;
        logic [15:0] ch, bits;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            n = $urandom_range(1, 20);
            repeat (n) add_byte(8'($urandom));
            send_file(0);
            return;
        end
        add_header();
        if (pick == 1) begin
            add_data($urandom_range(0, 4), 2); send_file(0); return;
        end
        if ($urandom_range(0, 2) == 0) begin
            push_tag($urandom); n = $urandom_range(0, 5); push_word_le(n);
            repeat (n + n % 2) add_byte(8'($urandom));
        end
        ch = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
        bits = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                           : ($urandom_range(0, 1) ? 16'd8 : 16'd16);
        add_fmt($urandom_range(0, 5) == 0 ? $urandom_range(0, 19) : 16,
                ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'd1, ch, $urandom, bits);
        n = $urandom_range(0, 12);
        if (pick == 2) add_data(n + 3, n);
        else if (pick == 3) begin
            send_file(0); return;
        end else add_data(n, n);
        send_file($urandom_range(0, 3));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed files: good, bad tags, short fmt, repeats, odd sizes, huge skip.
        add_header(); add_fmt(16, 1, 2, 32'hFFFF_FFFF, 16); add_data(3, 3); send_file(1);
        add_header(); add_fmt(16, 1, 1, 44100, 8); add_data(0, 0); send_file(0);
        push_tag(32'h5249_4647); send_file(0);
        push_tag(rwp_pkg::TAG_RIFF); push_word_le(0); push_tag(32'h5741_5646); send_file(2);
        add_byte(8'hFF); send_file(0);
        add_header(); add_data(2, 0); send_file(0);
        add_header(); add_fmt(3, 1, 0, 0, 0); add_data(1, 1); send_file(0);
        add_header(); add_fmt(16, 3, 1, 8000, 8); add_fmt(17, 1, 2, 8000, 8);
        add_data(5, 5); send_file(0);
        add_header(); add_fmt(16, 1, 3, 0, 24); add_data(1, 1); send_file(0);
        add_header(); push_tag(32'h4C49_5354); push_word_le(32'hFFFF_FFFF);
        add_byte(8'h00); send_file(0);
        add_header(); add_fmt(0, 0, 0, 0, 0); add_data(4, 2); send_file(0);
        add_header(); add_fmt(16, 1, 2, 22050, 8); send_file(0);

        // Hold off until every expected result has come.
        push <= 0;
        wait (sb.pending_results.size() == 0);
        @(posedge i_clk);

        while (bytes_sent < 600) begin
            random_gaps = ($urandom_range(0, 7) != 0);
            random_file();
        end
        push <= 0;
        wait (sb.pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/rwp_pkg.sv
rtl/rwp_front.sv
rtl/rwp_queue.sv
rtl/rwp_back.sv
rtl/riff_wav_pcm_header_parser_core.sv
verif/tb_riff_wav_pcm_header_parser_core.sv
